FILE: sv/mvte_pkg.sv
`default_nettype none

package mvte_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [2:0] SCRIPT_LEN = 3'd6;
  localparam logic [2:0] STYLE_LEN  = 3'd5;
  localparam logic [2:0] POS_MAX    = 3'd7;

  typedef struct packed {
    logic push;
    logic pop;
    logic push_bit;
  } stack_req_t;

  typedef struct packed {
    logic top_bit;
    logic at_root;
    logic full;
  } stack_status_t;

  function automatic logic [7:0] script_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h73;
      3'd1: ch = 8'h63;
      3'd2: ch = 8'h72;
      3'd3: ch = 8'h69;
      3'd4: ch = 8'h70;
      3'd5: ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] style_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h73;
      3'd1: ch = 8'h74;
      3'd2: ch = 8'h79;
      3'd3: ch = 8'h6C;
      3'd4: ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mvte_capture_stack.sv
`default_nettype none

module mvte_capture_stack
  import mvte_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire stack_req_t    req,
  output stack_status_t      status
);

  logic [STACK_DEPTH-1:0] bits;
  logic [LEVEL_W-1:0]     level;

  assign status.top_bit = bits[0];
  assign status.at_root = (level == LEVEL_W'(1));
  assign status.full    = (level == LEVEL_W'(STACK_DEPTH));

  // The top of the stack sits in bit 0; a push shifts the older bits upwards.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits  <= {{(STACK_DEPTH-1){1'b0}}, 1'b1};
      level <= LEVEL_W'(1);
    end else if (req.pop && !status.at_root) begin
      bits  <= {1'b0, bits[STACK_DEPTH-1:1]};
      level <= level - LEVEL_W'(1);
    end else if (req.push && !status.full) begin
      bits  <= {bits[STACK_DEPTH-2:0], req.push_bit};
      level <= level + LEVEL_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: sv/markup_visible_text_extractor_unit.sv
// A byte taken on the slave side waits in the input register; any result that it yields
// is then held in the result register, which presents it on the master side.
// Throughput: one byte per cycle unless stalled; the tag scan and stack update sit between
// the input and result registers. A held result with m_tready low stalls both stages.
// Reset (rst, synchronous, active high) leaves the block outside any tag, the stack
// at its root with text visible, and the fault flag clear.
`default_nettype none

module markup_visible_text_extractor_unit
  import mvte_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [7:0] text_byte, [8] stack_fault, [15:9] zero
);

  logic          advance;
  logic          step;
  logic          in_valid;
  logic [7:0]    in_byte;

  logic          inside_tag, inside_tag_next;
  logic          tag_started, tag_started_next;
  logic [2:0]    name_position, name_position_next;
  logic          name_finished, name_finished_next;
  logic          script_match, script_match_next;
  logic          style_match, style_match_next;
  logic          opens_slash, opens_slash_next;
  logic          ends_slash, ends_slash_next;
  logic          fault_seen, fault_seen_next;

  logic          is_lt, is_gt, is_slash, is_space;
  logic          closing, hidden, emit;
  logic [7:0]    emit_value;
  logic [7:0]    text_byte;
  logic          stack_fault;

  stack_req_t    sreq;
  stack_status_t sstat;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign step     = in_valid && advance;

  assign is_lt    = (in_byte == CHAR_LT);
  assign is_gt    = (in_byte == CHAR_GT);
  assign is_slash = (in_byte == CHAR_SLASH);
  assign is_space = (in_byte == CHAR_SPACE);

  assign closing = inside_tag && !is_lt && is_gt;
  assign hidden  = (script_match && (name_position == SCRIPT_LEN)) ||
                   (style_match && (name_position == STYLE_LEN));

  assign sreq.pop      = step && closing && opens_slash;
  assign sreq.push     = step && closing && !opens_slash && !ends_slash;
  assign sreq.push_bit = !hidden;

  always_comb begin
    inside_tag_next    = inside_tag;
    tag_started_next   = tag_started;
    name_position_next = name_position;
    name_finished_next = name_finished;
    script_match_next  = script_match;
    style_match_next   = style_match;
    opens_slash_next   = opens_slash;
    ends_slash_next    = ends_slash;
    fault_seen_next    = fault_seen;
    emit               = 1'b0;
    emit_value         = in_byte;

    if (is_lt || closing) begin
      inside_tag_next    = is_lt;
      tag_started_next   = 1'b0;
      name_position_next = 3'd0;
      name_finished_next = 1'b0;
      script_match_next  = 1'b1;
      style_match_next   = 1'b1;
      opens_slash_next   = 1'b0;
      ends_slash_next    = 1'b0;
      if (closing) begin
        if (opens_slash) begin
          if (sstat.at_root) begin
            fault_seen_next = 1'b1;
          end
        end else if (!ends_slash) begin
          if (sstat.full) begin
            fault_seen_next = 1'b1;
          end
          if (!hidden) begin
            emit       = 1'b1;
            emit_value = CHAR_SPACE;
          end
        end
      end
    end else if (inside_tag) begin
      if (!tag_started) begin
        opens_slash_next = is_slash;
      end
      tag_started_next = 1'b1;
      ends_slash_next  = is_slash;
      if (!name_finished) begin
        if (is_space) begin
          name_finished_next = 1'b1;
        end else begin
          if (name_position >= SCRIPT_LEN || script_char(name_position) != in_byte) begin
            script_match_next = 1'b0;
          end
          if (name_position >= STYLE_LEN || style_char(name_position) != in_byte) begin
            style_match_next = 1'b0;
          end
          if (name_position < POS_MAX) begin
            name_position_next = name_position + 3'd1;
          end
        end
      end
    end else begin
      emit = sstat.top_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      inside_tag    <= 1'b0;
      tag_started   <= 1'b0;
      name_position <= 3'd0;
      name_finished <= 1'b0;
      script_match  <= 1'b1;
      style_match   <= 1'b1;
      opens_slash   <= 1'b0;
      ends_slash    <= 1'b0;
      fault_seen    <= 1'b0;
    end else if (advance) begin
      in_valid <= s_tvalid;
      m_tvalid <= step && emit;
      if (step) begin
        inside_tag    <= inside_tag_next;
        tag_started   <= tag_started_next;
        name_position <= name_position_next;
        name_finished <= name_finished_next;
        script_match  <= script_match_next;
        style_match   <= style_match_next;
        opens_slash   <= opens_slash_next;
        ends_slash    <= ends_slash_next;
        fault_seen    <= fault_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_byte <= s_tdata;
      if (step) begin
        text_byte   <= emit_value;
        stack_fault <= fault_seen_next;
      end
    end
  end

  assign m_tdata = {7'd0, stack_fault, text_byte};

  mvte_capture_stack u_stack (
    .clk    (clk),
    .rst    (rst),
    .req    (sreq),
    .status (sstat)
  );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mvte_pkg::*;

  localparam logic [7:0] LT_CHAR    = 8'h3C;
  localparam logic [7:0] GT_CHAR    = 8'h3E;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [0:5][7:0] SCRIPT_WORD = "script";
  localparam logic [0:4][7:0] STYLE_WORD  = "style";
  localparam int SCRIPT_WORD_LEN = 6;
  localparam int STYLE_WORD_LEN  = 5;
  localparam int WORD_POS_TOP    = 7;
  localparam int OPENING_ROWS    = 25;
  localparam int ITEM_GOAL       = 1900;
  localparam int DIVE_OPENS      = 68;
  localparam int DIVE_CLOSES     = 70;
  localparam int LONG_HOLD_AT    = 300;
  localparam int LONG_HOLD       = 400;

  typedef struct packed {
    logic [7:0] text;
    logic       fault;
  } visible_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       checked;
    logic       yields;
    logic [7:0] text;
    logic       fault;
  } page_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  markup_visible_text_extractor_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predicted state of the tag scanner and the capture stack.
  logic       in_markup;
  logic       body_seen;
  logic [2:0] word_pos;
  logic       word_done;
  logic       may_be_script;
  logic       may_be_style;
  logic       lead_slash;
  logic       trail_slash;
  logic       show_bits [0:STACK_DEPTH-1];
  int         depth;
  logic       sticky_fault;

  page_row_t     opening_rows [0:OPENING_ROWS-1];
  page_row_t     page_rows [$];
  visible_byte_t text_due [$];
  int            taken;
  int            mismatch_count;
  int            gen_depth;
  bit            dive_done;
  bit            sender_calm;
  bit            sink_calm;
  int            drained;
  int            gap;
  int            hold;
  int            pick;
  logic          shows;
  logic [7:0]    shown;
  page_row_t     row;
  visible_byte_t due;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic forget_tag();
    body_seen     = 1'b0;
    word_pos      = 3'd0;
    word_done     = 1'b0;
    may_be_script = 1'b1;
    may_be_style  = 1'b1;
    lead_slash    = 1'b0;
    trail_slash   = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] c, output logic emits, output logic [7:0] txt);
    logic hidden;
    emits = 1'b0;
    txt = 8'h00;
    if (c == LT_CHAR) begin
      in_markup = 1'b1;
      forget_tag();
    end else if (in_markup) begin
      if (c == GT_CHAR) begin
        in_markup = 1'b0;
        if (lead_slash) begin
          if (depth > 1) depth--;
          else sticky_fault = 1'b1;
        end else if (!trail_slash) begin
          hidden = (may_be_script && word_pos == SCRIPT_WORD_LEN) ||
                   (may_be_style && word_pos == STYLE_WORD_LEN);
          if (depth < STACK_DEPTH) begin
            show_bits[depth] = !hidden;
            depth++;
          end else begin
            sticky_fault = 1'b1;
          end
          if (!hidden) begin
            emits = 1'b1;
            txt = SPACE_CHAR;
          end
        end
        forget_tag();
      end else begin
        if (!body_seen) lead_slash = (c == SLASH_CHAR);
        body_seen = 1'b1;
        trail_slash = (c == SLASH_CHAR);
        if (!word_done) begin
          if (c == SPACE_CHAR) begin
            word_done = 1'b1;
          end else begin
            if (word_pos >= SCRIPT_WORD_LEN) may_be_script = 1'b0;
            else if (SCRIPT_WORD[word_pos] != c) may_be_script = 1'b0;
            if (word_pos >= STYLE_WORD_LEN) may_be_style = 1'b0;
            else if (STYLE_WORD[word_pos] != c) may_be_style = 1'b0;
            if (word_pos < WORD_POS_TOP) word_pos++;
          end
        end
      end
    end else if (show_bits[depth-1]) begin
      emits = 1'b1;
      txt = c;
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    page_rows.push_back('{b, 1'b0, 1'b0, 8'h00, 1'b0});
  endtask

  task automatic put_word(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_name();
    case ($urandom_range(0, 13))
      0, 1: put_word("script");
      2, 3: put_word("style");
      4: put_word("scrip");
      5: put_word("scripts");
      6: put_word("styl");
      7: put_word("styles");
      8: put_word("style\t");
      9: ;
      10: put_word("p");
      11: put_word("div");
      default: repeat ($urandom_range(1, 9)) put_byte(8'($urandom_range(8'h61, 8'h7A)));
    endcase
  endtask

  task automatic put_open_tag();
    logic [7:0] b;
    put_byte(LT_CHAR);
    put_name();
    if ($urandom_range(0, 3) == 0) begin
      put_byte(SPACE_CHAR);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == LT_CHAR || b == GT_CHAR) b = DOT_CHAR;
        put_byte(b);
      end
    end
    if ($urandom_range(0, 6) == 0) put_byte(SLASH_CHAR);
    else gen_depth++;
    put_byte(GT_CHAR);
  endtask

  task automatic put_close_tag();
    put_byte(LT_CHAR);
    put_byte(SLASH_CHAR);
    put_name();
    if ($urandom_range(0, 7) == 0) put_byte(SLASH_CHAR);
    put_byte(GT_CHAR);
    if (gen_depth > 0) gen_depth--;
  endtask

  task automatic put_text();
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      b = 8'($urandom_range(0, 255));
      if (b == LT_CHAR && $urandom_range(0, 9) != 0) b = DOT_CHAR;
      put_byte(b);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_markup = 1'b0;
      forget_tag();
      for (int i = 0; i < STACK_DEPTH; i++) show_bits[i] = 1'b0;
      show_bits[0] = 1'b1;
      depth = 1;
      sticky_fault = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        row = page_rows[taken];
        taken++;
        scan_byte(s_tdata, shows, shown);
        if (row.checked && (shows !== row.yields ||
            (shows && (shown !== row.text || sticky_fault !== row.fault)))) begin
          $display("%0t: request %0d byte %h: expected yields %b text %h fault %b, actual %b %h %b",
                   $time, taken - 1, s_tdata, row.yields, row.text, row.fault,
                   shows, shown, sticky_fault);
          mismatch_count++;
        end
        if (shows) text_due.push_back('{shown, sticky_fault});
      end
      if (m_tvalid && m_tready) begin
        if (text_due.size() == 0) begin
          $display("%0t: result with none expected: expected nothing, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          due = text_due.pop_front();
          if (m_tdata[7:0] !== due.text) begin
            $display("%0t: text_byte expected %h, actual %h", $time, due.text, m_tdata[7:0]);
            mismatch_count++;
          end
          if (m_tdata[8] !== due.fault) begin
            $display("%0t: stack_fault expected %b, actual %b", $time, due.fault, m_tdata[8]);
            mismatch_count++;
          end
          if (m_tdata[15:9] !== 7'd0) begin
            $display("%0t: padding expected %h, actual %h", $time, 7'd0, m_tdata[15:9]);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    taken = 0;
    mismatch_count = 0;
    gen_depth = 0;
    dive_done = 1'b0;
    opening_rows = '{
      '{8'h00,      1'b1, 1'b1, 8'h00,      1'b0},
      '{8'hFF,      1'b1, 1'b1, 8'hFF,      1'b0},
      '{GT_CHAR,    1'b1, 1'b1, GT_CHAR,    1'b0},
      '{LT_CHAR,    1'b0, 1'b0, 8'h00,      1'b0},
      '{GT_CHAR,    1'b1, 1'b1, SPACE_CHAR, 1'b0},
      '{LT_CHAR,    1'b0, 1'b0, 8'h00,      1'b0},
      '{SLASH_CHAR, 1'b0, 1'b0, 8'h00,      1'b0},
      '{GT_CHAR,    1'b1, 1'b0, 8'h00,      1'b0},
      '{LT_CHAR,    1'b0, 1'b0, 8'h00,      1'b0},
      '{"s",        1'b0, 1'b0, 8'h00,      1'b0},
      '{LT_CHAR,    1'b0, 1'b0, 8'h00,      1'b0},
      '{"s",        1'b0, 1'b0, 8'h00,      1'b0},
      '{"t",        1'b0, 1'b0, 8'h00,      1'b0},
      '{"y",        1'b0, 1'b0, 8'h00,      1'b0},
      '{"l",        1'b0, 1'b0, 8'h00,      1'b0},
      '{"e",        1'b0, 1'b0, 8'h00,      1'b0},
      '{GT_CHAR,    1'b1, 1'b0, 8'h00,      1'b0},
      '{"Q",        1'b1, 1'b0, 8'h00,      1'b0},
      '{LT_CHAR,    1'b0, 1'b0, 8'h00,      1'b0},
      '{SLASH_CHAR, 1'b0, 1'b0, 8'h00,      1'b0},
      '{GT_CHAR,    1'b1, 1'b0, 8'h00,      1'b0},
      '{LT_CHAR,    1'b0, 1'b0, 8'h00,      1'b0},
      '{SLASH_CHAR, 1'b0, 1'b0, 8'h00,      1'b0},
      '{GT_CHAR,    1'b1, 1'b0, 8'h00,      1'b1},
      '{"z",        1'b1, 1'b1, "z",        1'b1}
    };
    for (int i = 0; i < OPENING_ROWS; i++) page_rows.push_back(opening_rows[i]);
    while (page_rows.size() < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (!dive_done && page_rows.size() > 800) begin
        dive_done = 1'b1;
        repeat (DIVE_OPENS) put_word("<i>");
        repeat (DIVE_CLOSES) put_word("</>");
        gen_depth = 0;
      end else if (pick < 35) begin
        put_text();
      end else if (pick < 88) begin
        if (gen_depth > 12 || (gen_depth > 0 && $urandom_range(0, 1) == 0)) put_close_tag();
        else put_open_tag();
      end else begin
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < page_rows.size(); i++) begin
      if (i % 64 == 0) sender_calm = ($urandom_range(0, 2) == 0);
      gap = sender_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= page_rows[i].data;
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
    while (text_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    drained = 0;
    sink_calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (drained % 64 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      if (drained == LONG_HOLD_AT) hold = LONG_HOLD;
      else hold = sink_calm ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      drained++;
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
